// ===== rtl/apsrt_pkg.sv =====
// apsrt_pkg: shared widths, reset values, register indexes and types
// for the audio pll sof rate tracker; used by apsrt_div and the top level
// no dependencies
package apsrt_pkg;

  localparam int NOMINAL_W   = 24;
  localparam int STEP_W      = 20;
  localparam int INTERVAL_W  = 8;
  localparam int FRAC_W      = 30;
  localparam int AVG_INIT_W  = 24;
  localparam int CAPTURE_W   = 32;
  localparam int AVERAGE_W   = 32;
  localparam int ERROR_W     = 32;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 30;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 64;

  localparam int AVERAGE_SHIFT_DEF = 3;
  localparam int WINDOW_SHIFT_DEF  = 7;

  localparam logic [CFG_INDEX_W-1:0] REG_NOMINAL  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STEP     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_INTERVAL = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAC     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_AVG      = 3'd4;

  localparam logic [NOMINAL_W-1:0]  NOMINAL_RST  = 24'd24576;
  localparam logic [STEP_W-1:0]     STEP_RST     = 20'd1;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 8'd8;
  localparam logic [FRAC_W-1:0]     FRAC_RST     = 30'd0;
  localparam logic [AVG_INIT_W-1:0] AVG_RST      = 24'd24576;
  localparam logic [FRAC_W-1:0]     FRAC_MAX     = {FRAC_W{1'b1}};

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/apsrt_div.sv =====
// apsrt_div: restoring divider, one quotient bit per cycle
// depends on apsrt_pkg for div_stat_t
module apsrt_div import apsrt_pkg::*; #(
  parameter int DVD_W = 32,
  parameter int DSR_W = 20
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DSR_W-1:0] divisor,
  output logic [DVD_W-1:0] quotient,
  output div_stat_t        stat
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_r;
  logic [DSR_W-1:0] rem_r;
  logic [DSR_W-1:0] dsr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DSR_W:0]   shifted;
  logic             ge;
  logic [DSR_W:0]   diff;
  logic [DSR_W-1:0] rem_nxt;

  // shift the next dividend bit into the partial remainder
  assign shifted = {rem_r, quo_r[DVD_W-1]};
  assign ge      = shifted >= {1'b0, dsr_r};
  assign diff    = shifted - {1'b0, dsr_r};
  assign rem_nxt = ge ? diff[DSR_W-1:0] : shifted[DSR_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DVD_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== rtl/audio_pll_sof_rate_tracker.sv =====
// audio_pll_sof_rate_tracker: tracks the usb frame rate against the audio pll
// and computes pll fraction corrections; depends on apsrt_pkg and apsrt_div
//
// usage:
//   in_*   one transaction per start-of-frame event: tdata[31:0] holds the
//          captured pll tick count, tdata[32] the link-attached flag
//   out_*  one result transaction per event: pll write strobe, fraction,
//          measured flag and signed tick error (see port comments)
//   cfg_*  register writes (index 0..4), taken at any time, meant for idle
// sequence: an event off the measuring interval goes straight to the output
//   state; one that fails the attach or window check passes the window check
//   first; a measured event runs a window check, the moving-average update
//   and a 32-step serial divide of the error by the step size
// throughput: one event at a time; the next event is accepted once the
//   result has moved into the output register
// reset: registers load their reset values, frame counter starts at one
// stall: a held result stays in the output register; a further result
//   waits in the sequencer, which takes no new event meanwhile
module audio_pll_sof_rate_tracker import apsrt_pkg::*; #(
  parameter int AVERAGE_SHIFT = AVERAGE_SHIFT_DEF,
  parameter int WINDOW_SHIFT  = WINDOW_SHIFT_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // [31:0] capture_value, [32] link_attached, [39:33] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [0] pll_write, [30:1] pll_fraction, [31] measured, [63:32] tick_error
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int REM_W = AVERAGE_SHIFT + 1;
  localparam int SUM_W = AVERAGE_SHIFT + 2;
  localparam logic signed [SUM_W-1:0] REM_LIM = SUM_W'(1) <<< AVERAGE_SHIFT;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WIN  = 3'd1;
  localparam logic [2:0] S_AVG1 = 3'd2;
  localparam logic [2:0] S_AVG2 = 3'd3;
  localparam logic [2:0] S_ERR  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_SAT  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]            state_r;
  logic [NOMINAL_W-1:0]  nominal_r;
  logic [STEP_W-1:0]     step_r;
  logic [INTERVAL_W-1:0] interval_r;
  logic [INTERVAL_W-1:0] frame_cnt_r;
  logic [CAPTURE_W-1:0]  last_cap_r;
  logic [AVERAGE_W-1:0]  avg_r;
  logic [REM_W-1:0]      rem_r;
  logic [FRAC_W-1:0]     frac_r;

  logic [CAPTURE_W-1:0]  period_r;
  logic                  attached_r;
  logic signed [32:0]    diff_r;
  logic                  err_neg_r;
  logic                  res_write_r;
  logic                  res_meas_r;
  logic [ERROR_W-1:0]    res_err_r;

  logic                  out_valid_r;
  logic                  out_write_r;
  logic [FRAC_W-1:0]     out_frac_r;
  logic                  out_meas_r;
  logic [ERROR_W-1:0]    out_err_r;

  logic                  in_fire;
  logic                  out_load;

  // window check
  logic signed [32:0]    dev_s;
  logic [32:0]           dev_abs;
  logic                  in_window;

  // moving average
  logic [32:0]           diff_mag;
  logic [32:0]           mag_q;
  logic [32:0]           q_full;
  logic [SUM_W-1:0]      r0;
  logic signed [SUM_W-1:0] rem_sum;
  logic [1:0]            q2;
  logic [SUM_W-1:0]      rem_adj;
  logic [AVERAGE_W-1:0]  avg_nxt;

  // error and divide
  logic signed [32:0]    err_s;
  logic [32:0]           err_abs;
  logic [STEP_W-1:0]     div_step;
  logic                  div_start;
  logic [31:0]           delta;
  div_stat_t             div_stat;

  // saturation
  logic [32:0]           f_sub;
  logic [32:0]           f_add;
  logic [FRAC_W-1:0]     frac_nxt;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_tready);

  assign dev_s     = $signed({1'b0, period_r}) - $signed({9'b0, nominal_r});
  assign dev_abs   = dev_s[32] ? 33'(-dev_s) : 33'(dev_s);
  assign in_window = dev_abs < 33'(nominal_r >> WINDOW_SHIFT);

  // truncating division of the difference by the average weight
  assign diff_mag = diff_r[32] ? 33'(-diff_r) : 33'(diff_r);
  assign mag_q    = diff_mag >> AVERAGE_SHIFT;
  assign q_full   = diff_r[32] ? 33'(-mag_q) : mag_q;
  assign r0       = diff_r[32] ? SUM_W'(-{2'b0, diff_mag[AVERAGE_SHIFT-1:0]})
                               : {2'b0, diff_mag[AVERAGE_SHIFT-1:0]};
  assign rem_sum  = $signed({rem_r[REM_W-1], rem_r}) + $signed(r0);

  // carried remainder spills at most one unit either way
  always_comb begin
    if (rem_sum >= REM_LIM) begin
      q2      = 2'b01;
      rem_adj = SUM_W'(rem_sum - REM_LIM);
    end else if (rem_sum <= -REM_LIM) begin
      q2      = 2'b11;
      rem_adj = SUM_W'(rem_sum + REM_LIM);
    end else begin
      q2      = 2'b00;
      rem_adj = SUM_W'(rem_sum);
    end
  end

  assign avg_nxt = avg_r + q_full[AVERAGE_W-1:0] + {{(AVERAGE_W-2){q2[1]}}, q2};

  assign err_s     = $signed({1'b0, avg_r}) - $signed({9'b0, nominal_r});
  assign err_abs   = err_s[32] ? 33'(-err_s) : 33'(err_s);
  assign div_step  = (step_r == '0) ? STEP_W'(1) : step_r;
  assign div_start = (state_r == S_ERR);

  apsrt_div #(
    .DVD_W (32),
    .DSR_W (STEP_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (err_abs[31:0]),
    .divisor  (div_step),
    .quotient (delta),
    .stat     (div_stat)
  );

  assign f_sub = {3'b0, frac_r} - {1'b0, delta};
  assign f_add = {3'b0, frac_r} + {1'b0, delta};

  always_comb begin
    if (!err_neg_r) begin
      frac_nxt = f_sub[32] ? '0 : f_sub[FRAC_W-1:0];
    end else begin
      frac_nxt = (f_add > {3'b0, FRAC_MAX}) ? FRAC_MAX : f_add[FRAC_W-1:0];
    end
  end

  // sequencer and tracking state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      nominal_r   <= NOMINAL_RST;
      step_r      <= STEP_RST;
      interval_r  <= INTERVAL_RST;
      frame_cnt_r <= INTERVAL_W'(1);
      last_cap_r  <= '0;
      avg_r       <= {{(AVERAGE_W-AVG_INIT_W){1'b0}}, AVG_RST};
      rem_r       <= '0;
      frac_r      <= FRAC_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_NOMINAL:  nominal_r  <= cfg_data[NOMINAL_W-1:0];
          REG_STEP:     step_r     <= cfg_data[STEP_W-1:0];
          REG_INTERVAL: interval_r <= cfg_data[INTERVAL_W-1:0];
          REG_FRAC:     frac_r     <= cfg_data[FRAC_W-1:0];
          REG_AVG: begin
            avg_r <= {{(AVERAGE_W-AVG_INIT_W){1'b0}}, cfg_data[AVG_INIT_W-1:0]};
            rem_r <= '0;
          end
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (frame_cnt_r != interval_r) begin
              frame_cnt_r <= frame_cnt_r + 1'b1;
              state_r     <= S_OUT;
            end else begin
              frame_cnt_r <= INTERVAL_W'(1);
              last_cap_r  <= in_tdata[CAPTURE_W-1:0];
              state_r     <= S_WIN;
            end
          end
        end
        S_WIN:  state_r <= (attached_r && in_window) ? S_AVG1 : S_OUT;
        S_AVG1: state_r <= S_AVG2;
        S_AVG2: begin
          avg_r   <= avg_nxt;
          rem_r   <= rem_adj[REM_W-1:0];
          state_r <= S_ERR;
        end
        S_ERR:  state_r <= S_DIV;
        S_DIV: begin
          if (div_stat.done) begin
            state_r <= S_SAT;
          end
        end
        S_SAT: begin
          if (delta != '0) begin
            frac_r <= frac_nxt;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // per-event working registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      period_r    <= in_tdata[CAPTURE_W-1:0] - last_cap_r;
      attached_r  <= in_tdata[CAPTURE_W];
      res_write_r <= 1'b0;
      res_meas_r  <= 1'b0;
      res_err_r   <= '0;
    end
    if (state_r == S_AVG1 - 3'd1) begin
      diff_r <= $signed({1'b0, period_r}) - $signed({1'b0, avg_r});
    end
    if (state_r == S_ERR) begin
      err_neg_r  <= err_s[32];
      res_meas_r <= 1'b1;
      res_err_r  <= err_s[ERROR_W-1:0];
    end
    if (state_r == S_SAT) begin
      res_write_r <= (delta != '0);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_write_r <= res_write_r;
      out_frac_r  <= (state_r == S_OUT) ? frac_r : out_frac_r;
      out_meas_r  <= res_meas_r;
      out_err_r   <= res_err_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_err_r, out_meas_r, out_frac_r, out_write_r};

endmodule
